// File: src/packbits_strided_channel_decoder_defines.svh
// Assertion macros shared by the PackBits lane decoder.
`ifndef PACKBITS_STRIDED_CHANNEL_DECODER_DEFINES_SVH
`define PACKBITS_STRIDED_CHANNEL_DECODER_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define PBSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define PBSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pbsd_pkg.sv
// Types and constants of the PackBits lane decoder.
package pbsd_pkg;

  localparam int CODE_W = 8;
  localparam int LANE_W = 2;
  localparam int ADDR_W = 12;
  localparam int CNT_W  = 8;

  localparam logic [CODE_W-1:0] HDR_NOP  = 8'h80;
  localparam logic [CODE_W-1:0] HDR_MASK = 8'hFF;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_LITERAL = 4'b0010,
    PH_REPEAT  = 4'b0100,
    PH_FULL    = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'b01,
    ST_EMIT   = 2'b10
  } ctl_state_t;

  typedef struct packed {
    logic take;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic rep_byte;
    logic lit_byte;
    logic emit_last;
  } sts_t;

endpackage

// File: src/pbsd_in_if.sv
// Input channel: compressed byte, stream start and lane.
interface pbsd_in_if;
  import pbsd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_byte;
  logic              stream_start;
  logic [LANE_W-1:0] lane;

  modport source (output valid, output code_byte, output stream_start, output lane,
                  input ready);
  modport sink   (input valid, input code_byte, input stream_start, input lane,
                  output ready);
endinterface

// File: src/pbsd_out_if.sv
// Result channel: tile write descriptors.
interface pbsd_out_if;
  import pbsd_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] write_address;
  logic [CODE_W-1:0] write_value;
  logic              second_write;
  logic              last_of_run;
  logic              tile_full;
  logic              overrun;

  modport source (output valid, output write_address, output write_value,
                  output second_write, output last_of_run, output tile_full,
                  output overrun, input ready);
  modport sink   (input valid, input write_address, input write_value,
                  input second_write, input last_of_run, input tile_full,
                  input overrun, output ready);
endinterface

// File: src/pbsd_ctrl.sv
// Controller: input/output handshakes and repeat expansion sequencing.
module pbsd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  pbsd_pkg::sts_t sts,
  output pbsd_pkg::cmd_t cmd
);
  import pbsd_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_ACCEPT: begin
        in_ready = out_free;
        cmd.take = in_valid && out_free;
        if (cmd.take && sts.lit_byte) begin
          out_valid_nxt = 1'b1;
        end
        if (cmd.take && sts.rep_byte) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = out_free;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (sts.emit_last) begin
            state_nxt = ST_ACCEPT;
          end
        end
      end
      default: begin
        state_nxt = ST_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCEPT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: src/pbsd_dp.sv
// Datapath: decoder state, run counters, address math and result register.
module pbsd_dp #(
  parameter int PIXELS_PER_TILE = 1024,
  parameter int BYTES_PER_PIXEL = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pbsd_pkg::CODE_W-1:0] code_byte,
  input  logic                        stream_start,
  input  logic [pbsd_pkg::LANE_W-1:0] lane,
  input  pbsd_pkg::cmd_t              cmd,
  output pbsd_pkg::sts_t              sts,
  output logic [pbsd_pkg::ADDR_W-1:0] write_address,
  output logic [pbsd_pkg::CODE_W-1:0] write_value,
  output logic                        second_write,
  output logic                        last_of_run,
  output logic                        tile_full,
  output logic                        overrun
);
  import pbsd_pkg::*;

  localparam int PIX_W = $clog2(PIXELS_PER_TILE + 1);
  localparam int CMP_W = (PIX_W > CNT_W) ? PIX_W : CNT_W;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [PIX_W-1:0]  p,
                                                input logic [LANE_W-1:0] l);
    addr_of = ADDR_W'(ADDR_W'(p) * ADDR_W'(BYTES_PER_PIXEL)) + ADDR_W'(l);
  endfunction

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  lit_r, lit_nxt;
  logic [CNT_W-1:0]  rep_r, rep_nxt;
  logic [PIX_W-1:0]  pix_r, pix_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;

  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [PIX_W-1:0]  epix_r, epix_nxt;
  logic [CODE_W-1:0] eval_r, eval_nxt;
  logic              efull_r, efull_nxt;
  logic              eover_r, eover_nxt;

  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [CODE_W-1:0] val_r, val_nxt;
  logic              sec_r, sec_nxt;
  logic              last_r, last_nxt;
  logic              full_r, full_nxt;
  logic              over_r, over_nxt;

  phase_t            ph_eff;
  logic [LANE_W-1:0] lane_eff;
  logic [PIX_W-1:0]  pix_eff;
  logic [CNT_W-1:0]  lit_eff;
  logic [CNT_W-1:0]  lit_dec;
  logic [PIX_W-1:0]  pix_inc;
  logic              lit_full;
  logic [CMP_W-1:0]  space_c;
  logic [CMP_W-1:0]  rep_c;
  logic              rep_over;
  logic [CNT_W-1:0]  rep_n;
  logic              rep_full;
  logic              e_last;

  assign ph_eff   = stream_start ? PH_HEADER : phase_r;
  assign lane_eff = stream_start ? lane : lane_r;
  assign pix_eff  = stream_start ? '0 : pix_r;
  assign lit_eff  = stream_start ? '0 : lit_r;
  assign lit_dec  = lit_eff - CNT_W'(1);
  assign pix_inc  = pix_eff + PIX_W'(1);
  assign lit_full = pix_inc >= PIX_W'(PIXELS_PER_TILE);
  assign space_c  = CMP_W'(PIX_W'(PIXELS_PER_TILE) - pix_eff);
  assign rep_c    = CMP_W'(rep_r);
  assign rep_over = rep_c > space_c;
  assign rep_n    = rep_over ? space_c[CNT_W-1:0] : rep_r;
  assign rep_full = CMP_W'(rep_n) == space_c;
  assign e_last   = rem_r <= CNT_W'(2);

  assign sts.rep_byte  = ph_eff == PH_REPEAT;
  assign sts.lit_byte  = ph_eff == PH_LITERAL;
  assign sts.emit_last = e_last;

  always_comb begin
    phase_nxt = phase_r;
    lit_nxt   = lit_r;
    rep_nxt   = rep_r;
    pix_nxt   = pix_r;
    lane_nxt  = lane_r;
    rem_nxt   = rem_r;
    epix_nxt  = epix_r;
    eval_nxt  = eval_r;
    efull_nxt = efull_r;
    eover_nxt = eover_r;
    addr_nxt  = addr_r;
    val_nxt   = val_r;
    sec_nxt   = sec_r;
    last_nxt  = last_r;
    full_nxt  = full_r;
    over_nxt  = over_r;
    if (cmd.take) begin
      if (stream_start) begin
        pix_nxt   = '0;
        lane_nxt  = lane;
        lit_nxt   = '0;
        rep_nxt   = '0;
        phase_nxt = PH_HEADER;
      end
      case (ph_eff)
        PH_HEADER: begin
          if (code_byte < HDR_NOP) begin
            lit_nxt   = CNT_W'(code_byte) + CNT_W'(1);
            phase_nxt = PH_LITERAL;
          end else if (code_byte > HDR_NOP) begin
            rep_nxt   = CNT_W'(code_byte ^ HDR_MASK) + CNT_W'(2);
            phase_nxt = PH_REPEAT;
          end
        end
        PH_LITERAL: begin
          addr_nxt = addr_of(pix_eff, lane_eff);
          val_nxt  = code_byte;
          sec_nxt  = 1'b0;
          last_nxt = 1'b1;
          full_nxt = lit_full;
          over_nxt = lit_full && (lit_dec != '0);
          pix_nxt  = pix_inc;
          lit_nxt  = lit_dec;
          if (lit_full) begin
            phase_nxt = PH_FULL;
          end else if (lit_dec == '0) begin
            phase_nxt = PH_HEADER;
          end
        end
        PH_REPEAT: begin
          rem_nxt   = rep_n;
          epix_nxt  = pix_eff;
          eval_nxt  = code_byte;
          efull_nxt = rep_full;
          eover_nxt = rep_over;
          pix_nxt   = pix_eff + PIX_W'(rep_n);
          rep_nxt   = '0;
          phase_nxt = rep_full ? PH_FULL : PH_HEADER;
        end
        default: begin
        end
      endcase
    end
    if (cmd.emit) begin
      addr_nxt = addr_of(epix_r, lane_r);
      val_nxt  = eval_r;
      sec_nxt  = rem_r > CNT_W'(1);
      last_nxt = e_last;
      full_nxt = e_last && efull_r;
      over_nxt = e_last && eover_r;
      rem_nxt  = e_last ? '0 : rem_r - CNT_W'(2);
      epix_nxt = epix_r + PIX_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      lit_r   <= '0;
      rep_r   <= '0;
      pix_r   <= '0;
      lane_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      lit_r   <= lit_nxt;
      rep_r   <= rep_nxt;
      pix_r   <= pix_nxt;
      lane_r  <= lane_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    epix_r  <= epix_nxt;
    eval_r  <= eval_nxt;
    efull_r <= efull_nxt;
    eover_r <= eover_nxt;
    addr_r  <= addr_nxt;
    val_r   <= val_nxt;
    sec_r   <= sec_nxt;
    last_r  <= last_nxt;
    full_r  <= full_nxt;
    over_r  <= over_nxt;
  end

  assign write_address = addr_r;
  assign write_value   = val_r;
  assign second_write  = sec_r;
  assign last_of_run   = last_r;
  assign tile_full     = full_r;
  assign overrun       = over_r;

endmodule

// File: src/packbits_strided_channel_decoder.sv
// Top level of the PackBits lane decoder: controller, datapath and checks.
//
// Decodes a PackBits byte stream into one byte lane of a tile of PIXELS_PER_TILE
// pixels, BYTES_PER_PIXEL bytes each. A header byte yields no result; a literal
// data byte yields one result. A repeat value byte is accepted and then expanded
// into ceil(n/2) results for a run of n pixels clipped to the tile, since each
// result covers up to two pixels and the single output register is loaded once
// per cycle while free; no new byte is taken until the last result is loaded. A
// stalled result transfer holds the block while out_ch.ready stays low. stream_start
// resets the pixel count, latches the lane and treats its byte as a header; after
// the tile fills, bytes are taken and dropped until the next stream_start.
module packbits_strided_channel_decoder #(
  parameter int PIXELS_PER_TILE = 1024,
  parameter int BYTES_PER_PIXEL = 4
) (
  input logic        clk,
  input logic        rst_n,
  pbsd_in_if.sink    in_ch,
  pbsd_out_if.source out_ch
);
  import pbsd_pkg::*;
  `include "packbits_strided_channel_decoder_defines.svh"

  cmd_t cmd;
  sts_t sts;

  pbsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pbsd_dp #(
    .PIXELS_PER_TILE (PIXELS_PER_TILE),
    .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .code_byte     (in_ch.code_byte),
    .stream_start  (in_ch.stream_start),
    .lane          (in_ch.lane),
    .cmd           (cmd),
    .sts           (sts),
    .write_address (out_ch.write_address),
    .write_value   (out_ch.write_value),
    .second_write  (out_ch.second_write),
    .last_of_run   (out_ch.last_of_run),
    .tile_full     (out_ch.tile_full),
    .overrun       (out_ch.overrun)
  );

  `PBSD_ASSERT_IMP(a_take_emit_excl, cmd.take, !cmd.emit, "take and emit in same cycle")
  `PBSD_ASSERT_NXT(a_rep_blocks_in, in_ch.valid && in_ch.ready && sts.rep_byte, !in_ch.ready, "input open during repeat expansion")
  `PBSD_ASSERT_NXT(a_run_continues, out_ch.valid && out_ch.ready && !out_ch.last_of_run, out_ch.valid, "gap inside repeat run")
  `PBSD_ASSERT_IMP(a_overrun_flags, out_ch.valid && out_ch.overrun, out_ch.tile_full && out_ch.last_of_run, "overrun without tile full on last result")

endmodule
